@@ hw/rtl/fq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fq_pkg
// Shared types and constants of the FIFO ready-queue scheduler: operation
// codes, engine states and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package fq_pkg;

    // identifier field width on the ports
    localparam int ID_W = 8;

    // default configuration
    localparam int QUEUE_DEPTH_DEFAULT = 32;
    localparam int ID_BITS_DEFAULT     = 8;

    // operation codes carried in kind
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_YIELD = 2'd1;
    localparam logic [1:0] KIND_TERM  = 2'd2;

    // engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YIELD,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    // result flags and identifier of one item
    typedef struct packed {
        logic            dispatch_valid;
        logic [ID_W-1:0] dispatch_id;
        logic            removed;
        logic            dropped;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/fq_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fq_engine
// Ring store of thread identifiers with head index and count. A sequencer
// reads, modifies and writes back the store: append, dequeue of the head,
// and a scan-then-compact pass for terminate.
// ----------------------------------------------------------------------------
module fq_engine #(
    parameter int QUEUE_DEPTH = fq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int ID_BITS     = fq_pkg::ID_BITS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            kind,
    input  wire logic [fq_pkg::ID_W-1:0]               thread_id,
    input  wire logic                                  id_valid,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output fq_pkg::res_t                               res,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]           res_occ
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [fq_pkg::ID_W-1:0] ID_MASK =
        fq_pkg::ID_W'((17'(1) << ID_BITS) - 17'(1));

    // ring position of an offset from the head, offset never above depth
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW:0]   off);
        logic [CW+1:0] sum;
        begin
            sum = (CW+2)'(base) + (CW+2)'(off);
            if (sum >= (CW+2)'(QUEUE_DEPTH))
            begin
                sum = sum - (CW+2)'(QUEUE_DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    fq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            off_reg, off_next;
    logic [fq_pkg::ID_W-1:0]  id_reg, id_next;
    logic                     fwd_reg, fwd_next;
    fq_pkg::res_t             res_reg, res_next;

    logic [fq_pkg::ID_W-1:0]  mem [QUEUE_DEPTH];
    logic [fq_pkg::ID_W-1:0]  rdata_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [AW-1:0]            mem_raddr;
    logic [fq_pkg::ID_W-1:0]  mem_wdata;

    logic [fq_pkg::ID_W-1:0]  id_masked;
    logic [CW:0]              off_p1;
    logic [CW:0]              off_p2;
    logic                     p1_in;
    logic                     p2_in;
    logic                     hit;
    logic                     full;

    assign id_masked = thread_id & ID_MASK;
    assign off_p1    = (CW+1)'(off_reg) + (CW+1)'(1);
    assign off_p2    = (CW+1)'(off_reg) + (CW+1)'(2);
    assign p1_in     = off_p1 < (CW+1)'(count_reg);
    assign p2_in     = off_p2 < (CW+1)'(count_reg);
    assign hit       = rdata_reg == id_reg;
    assign full      = count_reg == CW'(QUEUE_DEPTH);

    // entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == fq_pkg::KIND_YIELD)
                    begin
                        state_next = fq_pkg::ST_YIELD;
                    end
                    else if (kind == fq_pkg::KIND_TERM && id_valid &&
                             count_reg != '0)
                    begin
                        state_next = fq_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = fq_pkg::ST_RESULT;
                    end
                end
            end
            fq_pkg::ST_YIELD:
            begin
                state_next = fq_pkg::ST_RESULT;
            end
            fq_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = p1_in ? fq_pkg::ST_SHIFT : fq_pkg::ST_RESULT;
                end
                else if (!p1_in)
                begin
                    state_next = fq_pkg::ST_RESULT;
                end
            end
            fq_pkg::ST_SHIFT:
            begin
                if (!p2_in)
                begin
                    state_next = fq_pkg::ST_RESULT;
                end
            end
            fq_pkg::ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = fq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fq_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = state_reg == fq_pkg::ST_IDLE;
        res_valid = state_reg == fq_pkg::ST_RESULT;
    end

    assign res     = res_reg;
    assign res_occ = count_reg;

    // datapath: store access and register updates
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        off_next   = off_reg;
        id_next    = id_reg;
        fwd_next   = fwd_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = ring_pos(head_reg, (CW+1)'(count_reg));
        mem_wdata  = id_masked;
        mem_raddr  = head_reg;
        case (state_reg)
            fq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    id_next  = id_masked;
                    res_next = '0;
                    off_next = '0;
                    // head read and tail write meet only on an empty queue
                    fwd_next = count_reg == '0;
                    if ((kind inside {fq_pkg::KIND_ADD, fq_pkg::KIND_YIELD}) &&
                        id_valid)
                    begin
                        if (!full)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            res_next.dropped = 1'b1;
                        end
                    end
                end
            end
            fq_pkg::ST_YIELD:
            begin
                // dequeue the head
                if (count_reg != '0)
                begin
                    res_next.dispatch_valid = 1'b1;
                    res_next.dispatch_id    = fwd_reg ? id_reg : rdata_reg;
                    head_next  = ring_pos(head_reg, (CW+1)'(1));
                    count_next = count_reg - CW'(1);
                end
            end
            fq_pkg::ST_SCAN:
            begin
                // compare entry at off, fetch entry at off + 1
                mem_raddr = ring_pos(head_reg, off_p1);
                if (hit)
                begin
                    if (!p1_in)
                    begin
                        count_next       = count_reg - CW'(1);
                        res_next.removed = 1'b1;
                    end
                end
                else if (p1_in)
                begin
                    off_next = off_reg + CW'(1);
                end
            end
            fq_pkg::ST_SHIFT:
            begin
                // move entry off + 1 down to off, fetch off + 2
                mem_we    = 1'b1;
                mem_waddr = ring_pos(head_reg, (CW+1)'(off_reg));
                mem_wdata = rdata_reg;
                mem_raddr = ring_pos(head_reg, off_p2);
                if (p2_in)
                begin
                    off_next = off_reg + CW'(1);
                end
                else
                begin
                    count_next       = count_reg - CW'(1);
                    res_next.removed = 1'b1;
                end
            end
            fq_pkg::ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        id_reg  <= id_next;
        fwd_reg <= fwd_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/fifo_ready_queue_scheduler.sv @@
`default_nettype none
// Path from accept to out_valid: add goes straight to the result, yield through the
// yield state, terminate scans to the match and then moves each later entry down;
// the sequencer makes one-read one-write passes over the store.
// The engine takes no new item before its result leaves it; an item is taken
// while the previous result waits in the output register.
// Reset: head and count cleared (queue empty); store contents left undefined.
// ----------------------------------------------------------------------------
// fifo_ready_queue_scheduler
// FIFO ready queue of thread identifiers with add, yield and terminate,
// followed by an output register on the result channel.
// ----------------------------------------------------------------------------
module fifo_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = fq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int ID_BITS     = fq_pkg::ID_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         kind,
    input  wire logic [fq_pkg::ID_W-1:0]            thread_id,
    input  wire logic                               id_valid,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    dispatch_valid,
    output logic [fq_pkg::ID_W-1:0]                 dispatch_id,
    output logic                                    removed,
    output logic                                    dropped,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]        occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          res_valid;
    logic          res_ready;
    fq_pkg::res_t  res;
    logic [CW-1:0] res_occ;

    logic          out_valid_reg;
    fq_pkg::res_t  out_res_reg;
    logic [CW-1:0] out_occ_reg;

    fq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .thread_id (thread_id),
        .id_valid  (id_valid),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .res_occ   (res_occ)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
            out_occ_reg <= res_occ;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dispatch_valid = out_res_reg.dispatch_valid;
    assign dispatch_id    = out_res_reg.dispatch_id;
    assign removed        = out_res_reg.removed;
    assign dropped        = out_res_reg.dropped;
    assign occupancy      = out_occ_reg;

    // an accepted item keeps the engine busy in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("engine took a second item back to back");

    // occupancy stays within the store
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // a dropped append only happens on a full queue
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> occupancy >= CW'(QUEUE_DEPTH - 1))
        else $error("append dropped below full");

    // removal comes from a different operation than dispatch or drop
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(dispatch_valid && removed) && !(removed && dropped))
        else $error("conflicting result flags");

endmodule

`default_nettype wire
